[design/nrmc_pkg.sv]
// shared types, constants and helpers for the nmea rmc position extractor
`timescale 1ns / 1ps
`default_nettype none

package nrmc_pkg;

	// default sentence and field limits
	localparam int MAX_SENTENCE_DEF = 99;
	localparam int MAX_FIELD_DEF    = 24;

	// sentence header and field numbering
	localparam int HEADER_LEN = 6;
	localparam int COMMA_W    = 3;

	localparam logic [COMMA_W-1:0] FIELD_STATUS = COMMA_W'(2);
	localparam logic [COMMA_W-1:0] FIELD_LAT    = COMMA_W'(3);
	localparam logic [COMMA_W-1:0] FIELD_LON    = COMMA_W'(5);

	// character codes
	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_VOID    = 8'h56;

	typedef enum logic [1:0] {
		KIND_LAT  = 2'd0,
		KIND_LON  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// one result from the parser toward the output register
	typedef struct packed {
		logic       vld;
		kind_t      kind;
		logic [7:0] char_out;
		logic       fix_valid;
	} nrmc_res_t;

	// expected header byte at a given sentence position
	function automatic logic [7:0] header_byte(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0: ch = 8'h24; // $
			3'd1: ch = 8'h47; // G
			3'd2: ch = 8'h50; // P
			3'd3: ch = 8'h52; // R
			3'd4: ch = 8'h4D; // M
			3'd5: ch = 8'h43; // C
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[design/nrmc_ifs.sv]
// valid/ready channel interfaces for received bytes and extracted results
`timescale 1ns / 1ps
`default_nettype none

interface nrmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_res_if;
	import nrmc_pkg::*;

	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] char_out;
	logic       fix_valid;

	modport source (output valid, output kind, output char_out, output fix_valid, input ready);
	modport sink (input valid, input kind, input char_out, input fix_valid, output ready);
endinterface

`default_nettype wire

[design/nrmc_in_stage.sv]
// input register holding one received byte for the parser
`timescale 1ns / 1ps
`default_nettype none

module nrmc_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	nrmc_byte_if.sink       rx,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic       valid_s1_r;
	logic [7:0] byte_s1_r;
	logic       take;

	assign rx.ready = !valid_s1_r || advance;
	assign take     = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (rx.ready) begin
			valid_s1_r <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1_r <= rx.rx_byte;
		end
	end

	assign valid_s1 = valid_s1_r;
	assign byte_s1  = byte_s1_r;

endmodule

`default_nettype wire

[design/nrmc_parse.sv]
// sentence state and per-byte field extraction
`timescale 1ns / 1ps
`default_nettype none

module nrmc_parse #(
	parameter int MAX_SENTENCE = nrmc_pkg::MAX_SENTENCE_DEF,
	parameter int MAX_FIELD    = nrmc_pkg::MAX_FIELD_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        advance,
	input  wire logic [7:0]  byte_s1,
	output nrmc_pkg::nrmc_res_t res
);
	import nrmc_pkg::*;

	localparam int PW = $clog2(MAX_SENTENCE);
	localparam int FW = $clog2(MAX_FIELD + 1);

	logic               in_sent_q,  in_sent_n;
	logic [PW-1:0]      pos_q,      pos_n;
	logic               hdr_ok_q,   hdr_ok_n;
	logic [COMMA_W-1:0] comma_q,    comma_n;
	logic               fix_bad_q,  fix_bad_n;
	logic [FW-1:0]      fcnt_q,     fcnt_n;
	logic               hdr_cur;

	always_comb begin
		in_sent_n = in_sent_q;
		pos_n     = pos_q;
		hdr_ok_n  = hdr_ok_q;
		comma_n   = comma_q;
		fix_bad_n = fix_bad_q;
		fcnt_n    = fcnt_q;
		hdr_cur   = hdr_ok_q;
		res       = '{vld: 1'b0, kind: KIND_LAT, char_out: 8'h00, fix_valid: 1'b0};

		if (!in_sent_q) begin
			if (byte_s1 == CHAR_DOLLAR) begin
				in_sent_n = 1'b1;
				pos_n     = PW'(1);
				hdr_ok_n  = 1'b1;
				comma_n   = '0;
				fix_bad_n = 1'b0;
				fcnt_n    = '0;
			end
		end else if (byte_s1 == CHAR_NEWLINE || pos_q >= PW'(MAX_SENTENCE - 1)) begin
			// end of sentence: report only for a full rmc header
			in_sent_n = 1'b0;
			pos_n     = '0;
			if (hdr_ok_q && pos_q >= PW'(HEADER_LEN)) begin
				res = '{vld: 1'b1, kind: KIND_DONE, char_out: 8'h00, fix_valid: !fix_bad_q};
			end
		end else begin
			if (pos_q < PW'(HEADER_LEN) && byte_s1 != header_byte(pos_q[2:0])) begin
				hdr_cur = 1'b0;
			end
			hdr_ok_n = hdr_cur;
			pos_n    = pos_q + PW'(1);

			if (byte_s1 == CHAR_COMMA) begin
				// saturating field number, only small values matter
				if (comma_q != '1) begin
					comma_n = comma_q + COMMA_W'(1);
				end
				fcnt_n = '0;
			end else if (hdr_cur && !fix_bad_q) begin
				if (comma_q == FIELD_STATUS) begin
					if (byte_s1 == CHAR_VOID) begin
						fix_bad_n = 1'b1;
					end
				end else if ((comma_q == FIELD_LAT || comma_q == FIELD_LON)
				             && fcnt_q < FW'(MAX_FIELD)) begin
					fcnt_n = fcnt_q + FW'(1);
					res = '{vld: 1'b1,
					        kind: (comma_q == FIELD_LAT) ? KIND_LAT : KIND_LON,
					        char_out: byte_s1, fix_valid: 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			pos_q     <= '0;
			hdr_ok_q  <= 1'b1;
			comma_q   <= '0;
			fix_bad_q <= 1'b0;
			fcnt_q    <= '0;
		end else if (advance) begin
			in_sent_q <= in_sent_n;
			pos_q     <= pos_n;
			hdr_ok_q  <= hdr_ok_n;
			comma_q   <= comma_n;
			fix_bad_q <= fix_bad_n;
			fcnt_q    <= fcnt_n;
		end
	end

endmodule

`default_nettype wire

[design/nrmc_out_stage.sv]
// result register driving the output channel
`timescale 1ns / 1ps
`default_nettype none

module nrmc_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nrmc_pkg::nrmc_res_t  res_in,
	input  wire logic                 advance,
	output logic                      free,
	nrmc_res_if.source                res
);
	import nrmc_pkg::*;

	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] char_q;
	logic       fix_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_in.vld;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_in.vld) begin
			kind_q <= res_in.kind;
			char_q <= res_in.char_out;
			fix_q  <= res_in.fix_valid;
		end
	end

	assign res.valid     = valid_q;
	assign res.kind      = kind_q;
	assign res.char_out  = char_q;
	assign res.fix_valid = fix_q;

endmodule

`default_nettype wire

[design/nmea_rmc_position_extractor_core.sv]
// top level of the nmea rmc position extractor
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per transaction on rx and returns latitude
// and longitude characters of "$GPRMC" sentences on res, followed by one done
// transaction per rmc sentence that carries the fix flag (0 after a 'V' in the
// status field). A sentence opens on '$' and closes on a newline or on its
// MAX_SENTENCE-th byte; sentences with any other header give nothing. Each
// field yields at most MAX_FIELD characters. Throughput is one byte per clock
// cycle while res is not stalled. A byte that yields a result passes through a
// byte register in front of the parser and a result register behind it, with
// one pass of parser logic in between. When the result register is full and
// res.ready is low, rx.ready drops as soon as a byte waits in the byte
// register; otherwise rx is ready every cycle.

module nmea_rmc_position_extractor_core #(
	parameter int MAX_SENTENCE = nrmc_pkg::MAX_SENTENCE_DEF,
	parameter int MAX_FIELD    = nrmc_pkg::MAX_FIELD_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	nrmc_byte_if.sink   rx,
	nrmc_res_if.source  res
);
	import nrmc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;
	nrmc_res_t  parse_res;

	// the parser steps whenever a byte waits and the result register can take it
	assign advance = valid_s1 && out_free;

	nrmc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// sentence tracking and extraction
	nrmc_parse #(
		.MAX_SENTENCE (MAX_SENTENCE),
		.MAX_FIELD    (MAX_FIELD)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.res     (parse_res)
	);

	// result register, drained by the downstream consumer
	nrmc_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res_in  (parse_res),
		.advance (advance),
		.free    (out_free),
		.res     (res)
	);

endmodule

`default_nettype wire

[design/nrmc_checker.sv]
// port-level checks for the nmea rmc position extractor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module nrmc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] out_kind,
	input wire logic [7:0] out_char,
	input wire logic       out_fix
);
	import nrmc_pkg::*;

	// a done transaction carries no character
	a_done_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_DONE |-> out_char == 8'h00)
		else $error("done result with nonzero character");

	// character transactions never claim a fix
	a_char_no_fix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_DONE |-> !out_fix)
		else $error("character result with fix flag set");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
		&& $stable(out_char) && $stable(out_fix))
		else $error("stalled result changed");

	// a fresh result traces back to an accepted byte transaction
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding byte transaction");

endmodule

bind nmea_rmc_position_extractor_core nrmc_checker u_nrmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rx.valid),
	.in_ready  (rx.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_kind  (res.kind),
	.out_char  (res.char_out),
	.out_fix   (res.fix_valid)
);

`default_nettype wire
